[rtl/prominent_peak_finder_assert.svh]
// assertion macros for the peak finder
`ifndef PROMINENT_PEAK_FINDER_ASSERT_SVH
`define PROMINENT_PEAK_FINDER_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define PPF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("peak finder check failed");

// antecedent implies consequent in the same cycle
`define PPF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("peak finder check failed");

`else

`define PPF_ASSERT_ALWAYS(lbl, cond)
`define PPF_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

[rtl/ppf_pkg.sv]
package ppf_pkg;

    localparam int MaxSamples = 512;
    localparam int MaxCand    = 32;
    localparam int SampleW    = 16;
    localparam int AddrW      = $clog2(MaxSamples);
    localparam int CountW     = AddrW + 1;
    localparam int CandW      = $clog2(MaxCand);
    localparam int CandCntW   = CandW + 1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_PEAK = 2'd1,
        STATUS_SHORT   = 2'd2,
        STATUS_TOOMANY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_PROM_THR  = 2'd0,
        REG_GRAD_THR  = 2'd1,
        REG_NOISE     = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_IDX,
        ST_PEAK,
        ST_PEAKW,
        ST_LRD,
        ST_LCHK,
        ST_RRD,
        ST_RCHK,
        ST_EVAL,
        ST_OUT
    } state_t;

endpackage

[rtl/prominent_peak_finder.sv]
// channel   | dir | handshake            | word
// s_ input  | in  | s_tvalid / s_tready  | tdata = sample, tlast = last
// m_ result | out | m_tvalid / m_tready  | tuser = status, tdata = index, prominence
// cfg       | in  | cfg_wr_en            | cfg_addr selects register, cfg_wdata value
//
// samples are taken one per cycle into a 512-word store while loading
// after last the block scans the record through the single store read port:
// a candidate scan, then per candidate a walk left and right over the
// samples examined; input is stalled meanwhile
// a result waits in the output register; the next record is taken only after
// it has been loaded there
// reset (aresetn low, synchronous) clears control state and loads the config defaults
`include "prominent_peak_finder_assert.svh"

module prominent_peak_finder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [8:0] peak position, [24:9] prominence, zero above
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import ppf_pkg::*;

    // configuration
    logic signed [31:0] prom_thr_reg, grad_thr_reg, noise_reg;

    // sample store, registered read
    logic signed [SampleW-1:0] mem [MaxSamples];
    logic signed [SampleW-1:0] q_reg;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;

    // control
    state_t state_reg, state_next;
    logic [CountW-1:0]   cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [CandCntW-1:0] cc_reg, cc_next;
    logic [CandW-1:0]    ci_reg, ci_next;
    logic                found_reg, found_next;
    logic [CountW-1:0]   ra_reg, ra_next;
    logic [CountW-1:0]   rk_reg, rk_next;
    logic                rv_reg, rv_next;
    logic                m_tvalid_reg, m_tvalid_next;
    status_t             res_status_reg, res_status_next;

    // payload
    logic signed [SampleW-1:0] w1_reg, w1_next, w2_reg, w2_next;
    logic signed [33:0]        gprev_reg, gprev_next;
    logic [AddrW-1:0]          cand_list [MaxCand];
    logic [AddrW-1:0]          cand_rd_reg;
    logic                      cand_we;
    logic [AddrW-1:0]          p_reg, p_next;
    logic [CountW-1:0]         ptr_reg, ptr_next;
    logic signed [SampleW-1:0] peak_reg, peak_next, lmin_reg, lmin_next, rmin_reg, rmin_next;
    logic [15:0]               best_reg, best_next;
    logic [AddrW-1:0]          bidx_reg, bidx_next;
    logic [31:0]               m_tdata_reg, m_tdata_next;
    logic [1:0]                m_tuser_reg, m_tuser_next;

    // scan datapath
    logic signed [16:0] d_first, d_cent;
    logic signed [33:0] gcur, mag;
    logic               gprev_pos, gcur_nonpos, zc, lmax, above, steep, is_cand;
    // prominence evaluation
    logic signed [SampleW-1:0] base;
    logic signed [16:0]        pr_full;
    logic [15:0]               pr;
    logic                      pr_ok;
    logic [CountW-1:0]         p_plus1;
    logic                      take_in, out_free;

    assign s_tready = (state_reg == ST_LOAD);
    assign take_in  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign d_first     = {q_reg[15], q_reg} - {w2_reg[15], w2_reg};
    assign d_cent      = {q_reg[15], q_reg} - {w1_reg[15], w1_reg};
    assign gcur        = {{2{d_cent[16]}}, d_cent, 15'b0};
    assign gprev_pos   = !gprev_reg[33] && (gprev_reg != '0);
    assign gcur_nonpos = gcur[33] || (gcur == '0);
    assign zc          = gprev_pos && gcur_nonpos;
    assign lmax        = (w2_reg > w1_reg) && (w2_reg > q_reg);
    assign above       = $signed({w2_reg, 16'b0}) > noise_reg;
    assign mag         = gprev_reg[33] ? -gprev_reg : gprev_reg;
    assign steep       = mag >= $signed({{2{grad_thr_reg[31]}}, grad_thr_reg});
    assign is_cand     = (zc || lmax) && above && steep;

    assign base    = (lmin_reg > rmin_reg) ? lmin_reg : rmin_reg;
    assign pr_full = {peak_reg[15], peak_reg} - {base[15], base};
    assign pr      = pr_full[15:0];
    assign pr_ok   = $signed({1'b0, pr, 16'b0}) >= $signed({prom_thr_reg[31], prom_thr_reg});
    assign p_plus1 = {1'b0, p_reg} + 1'b1;

    always_comb begin
        case (state_reg)
            ST_SCAN: rd_addr = ra_reg[AddrW-1:0];
            ST_PEAK: rd_addr = cand_rd_reg;
            default: rd_addr = ptr_reg[AddrW-1:0];
        endcase
    end

    assign wr_en = take_in && !cnt_reg[CountW-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[AddrW-1:0]] <= s_tdata;
        end
        q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cand_we) begin
            cand_list[cc_reg[CandW-1:0]] <= rk_reg[AddrW-1:0] - 1'b1;
        end
        cand_rd_reg <= cand_list[ci_reg];
    end

    always_comb begin
        logic [CountW-1:0]   newcnt;
        logic                ovf_now;
        logic [CandCntW-1:0] cc_after;
        logic                stop;
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        cc_next         = cc_reg;
        ci_next         = ci_reg;
        found_next      = found_reg;
        ra_next         = ra_reg;
        rk_next         = rk_reg;
        rv_next         = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        res_status_next = res_status_reg;
        w1_next         = w1_reg;
        w2_next         = w2_reg;
        gprev_next      = gprev_reg;
        cand_we         = 1'b0;
        p_next          = p_reg;
        ptr_next        = ptr_reg;
        peak_next       = peak_reg;
        lmin_next       = lmin_reg;
        rmin_next       = rmin_reg;
        best_next       = best_reg;
        bidx_next       = bidx_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        newcnt          = cnt_reg + {{(CountW-1){1'b0}}, !cnt_reg[CountW-1]};
        ovf_now         = ovf_reg || cnt_reg[CountW-1];
        cc_after        = cc_reg;
        stop            = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (take_in) begin
                    cnt_next = newcnt;
                    ovf_next = ovf_now;
                    if (s_tlast) begin
                        ra_next    = '0;
                        cc_next    = '0;
                        found_next = 1'b0;
                        best_next  = '0;
                        bidx_next  = '0;
                        if (ovf_now) begin
                            res_status_next = STATUS_TOOMANY;
                            state_next      = ST_OUT;
                        end else if (newcnt < CountW'(3)) begin
                            res_status_next = STATUS_SHORT;
                            state_next      = ST_OUT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // stream the record through a three-sample window
                if (ra_reg < cnt_reg) begin
                    ra_next = ra_reg + 1'b1;
                    rv_next = 1'b1;
                    rk_next = ra_reg;
                end
                if (rv_reg) begin
                    w1_next = w2_reg;
                    w2_next = q_reg;
                    if (rk_reg == CountW'(1)) begin
                        gprev_next = {d_first[16], d_first, 16'b0};
                    end else if (rk_reg >= CountW'(2)) begin
                        gprev_next = gcur;
                        if (is_cand) begin
                            if (!cc_reg[CandCntW-1]) begin
                                cand_we  = 1'b1;
                                cc_after = cc_reg + 1'b1;
                            end else begin
                                stop = 1'b1;
                            end
                        end
                        if (rk_reg == cnt_reg - 1'b1) begin
                            stop = 1'b1;
                        end
                    end
                    cc_next = cc_after;
                    if (stop) begin
                        rv_next = 1'b0;
                        ci_next = '0;
                        if (cc_after == '0) begin
                            res_status_next = STATUS_NO_PEAK;
                            state_next      = ST_OUT;
                        end else begin
                            state_next = ST_IDX;
                        end
                    end
                end
            end
            ST_IDX: begin
                // candidate list read is registered, wait for it
                state_next = ST_PEAK;
            end
            ST_PEAK: begin
                p_next     = cand_rd_reg;
                state_next = ST_PEAKW;
            end
            ST_PEAKW: begin
                peak_next = q_reg;
                lmin_next = q_reg;
                rmin_next = q_reg;
                if (p_reg == '0) begin
                    ptr_next   = p_plus1;
                    state_next = (p_plus1 >= cnt_reg) ? ST_EVAL : ST_RRD;
                end else begin
                    ptr_next   = {1'b0, p_reg} - 1'b1;
                    state_next = ST_LRD;
                end
            end
            ST_LRD: begin
                state_next = ST_LCHK;
            end
            ST_LCHK: begin
                // walk left until a sample reaches the peak or the record start
                if (q_reg >= peak_reg || ptr_reg == '0) begin
                    if (q_reg < peak_reg && q_reg < lmin_reg) begin
                        lmin_next = q_reg;
                    end
                    ptr_next   = p_plus1;
                    state_next = (p_plus1 >= cnt_reg) ? ST_EVAL : ST_RRD;
                end else begin
                    if (q_reg < lmin_reg) begin
                        lmin_next = q_reg;
                    end
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_LRD;
                end
            end
            ST_RRD: begin
                state_next = ST_RCHK;
            end
            ST_RCHK: begin
                // walk right until a sample reaches the peak or the record end
                if (q_reg >= peak_reg) begin
                    state_next = ST_EVAL;
                end else begin
                    if (q_reg < rmin_reg) begin
                        rmin_next = q_reg;
                    end
                    if (ptr_reg == cnt_reg - 1'b1) begin
                        state_next = ST_EVAL;
                    end else begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_RRD;
                    end
                end
            end
            ST_EVAL: begin
                // keep the earliest strictly largest prominence that meets the threshold
                if (pr_ok && (!found_reg || pr > best_reg)) begin
                    found_next = 1'b1;
                    best_next  = pr;
                    bidx_next  = p_reg;
                end
                ci_next = ci_reg + 1'b1;
                if ({1'b0, ci_reg} + 1'b1 == cc_reg) begin
                    res_status_next = (pr_ok && (!found_reg || pr > best_reg) || found_reg)
                                      ? STATUS_OK : STATUS_NO_PEAK;
                    state_next      = ST_OUT;
                end else begin
                    state_next = ST_IDX;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    if (res_status_reg == STATUS_OK) begin
                        m_tdata_next = {7'b0, best_reg, bidx_reg};
                    end else begin
                        m_tdata_next = '0;
                    end
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    cc_next    = '0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            cc_reg         <= '0;
            ci_reg         <= '0;
            found_reg      <= 1'b0;
            ra_reg         <= '0;
            rk_reg         <= '0;
            rv_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            res_status_reg <= STATUS_OK;
            prom_thr_reg   <= 32'sd65536;
            grad_thr_reg   <= 32'sd6553;
            noise_reg      <= 32'sd655360;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            cc_reg         <= cc_next;
            ci_reg         <= ci_next;
            found_reg      <= found_next;
            ra_reg         <= ra_next;
            rk_reg         <= rk_next;
            rv_reg         <= rv_next;
            m_tvalid_reg   <= m_tvalid_next;
            res_status_reg <= res_status_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_PROM_THR: prom_thr_reg <= cfg_wdata;
                    REG_GRAD_THR: grad_thr_reg <= cfg_wdata;
                    REG_NOISE:    noise_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        w1_reg      <= w1_next;
        w2_reg      <= w2_next;
        gprev_reg   <= gprev_next;
        p_reg       <= p_next;
        ptr_reg     <= ptr_next;
        peak_reg    <= peak_next;
        lmin_reg    <= lmin_next;
        rmin_reg    <= rmin_next;
        best_reg    <= best_next;
        bidx_reg    <= bidx_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // checks
    `PPF_ASSERT_ALWAYS(a_cand_bound, cc_reg <= CandCntW'(MaxCand))
    `PPF_ASSERT_IMPLY(a_fail_zero, m_tvalid && m_tuser != STATUS_OK, m_tdata == '0)
    `PPF_ASSERT_IMPLY(a_scan_len, state_reg == ST_SCAN, cnt_reg >= CountW'(3) && !ovf_reg)
    `PPF_ASSERT_IMPLY(a_count_cap, s_tready, cnt_reg <= CountW'(MaxSamples))

endmodule
